[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for same-cycle and next-cycle implication checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

[rtl/rsfr_pkg.sv]
// ----------------------------------------------------------------------------
// rsfr_pkg
// Types, codes and constants of the frame receiver.
// ----------------------------------------------------------------------------
package rsfr_pkg;

    localparam int BUFFER_BYTES_DEF = 64;

    localparam logic [7:0] PREAMBLE_BYTE = 8'hFE;
    localparam logic [7:0] HEADER_BYTE   = 8'h68;

    // item operation codes
    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_NODE_MODE  = 3'd0;
    localparam logic [2:0] CFG_SKIP_PRE   = 3'd1;
    localparam logic [2:0] CFG_NO_HEADER  = 3'd2;
    localparam logic [2:0] CFG_LEN_POS    = 3'd3;
    localparam logic [2:0] CFG_LEN_SCALE  = 3'd4;
    localparam logic [2:0] CFG_LEN_OFFSET = 3'd5;

    typedef enum logic [2:0] {
        ST_STORED   = 3'd0,
        ST_BUSY     = 3'd1,
        ST_PREAMBLE = 3'd2,
        ST_BADLEN   = 3'd3,
        ST_BADSUM   = 3'd4,
        ST_DONE     = 3'd5,
        ST_RELEASED = 3'd6,
        ST_READ     = 3'd7
    } t_status;

    typedef struct packed {
        t_status    status;
        logic       frame_ready;
        logic [7:0] frame_length;
        logic       start_seen;
    } t_res;

    typedef struct packed {
        logic       we;
        logic [2:0] index;
        logic [7:0] data;
    } t_cfg_wr;

    // one access to the frame store; addr is cut to the store's width there
    typedef struct packed {
        logic       en;
        logic       we;
        logic       re;
        logic [7:0] addr;
        logic [7:0] wdata;
    } t_mem_req;

endpackage

[rtl/rsfr_store.sv]
// ----------------------------------------------------------------------------
// rsfr_store
// Frame buffer memory with per-entry valid bits and registered read data.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsfr_store #(
    parameter int BUFFER_BYTES = rsfr_pkg::BUFFER_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rsfr_pkg::t_mem_req i_req,
    output logic [7:0]       o_rdata
);
    import rsfr_pkg::*;

    localparam int DEPTH = BUFFER_BYTES + 2;
    localparam int AW    = $clog2(DEPTH);

    logic [7:0]       r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [7:0]       r_q;
    logic             r_hit;
    logic [AW-1:0]    addr;

    assign addr = i_req.addr[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_req.en && i_req.we) begin
            r_mem[addr] <= i_req.wdata;
        end
        if (i_req.en) begin
            r_q <= r_mem[addr];
        end
    end

    // an entry never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_hit   <= 1'b0;
        end else if (i_req.en) begin
            if (i_req.we) begin
                r_valid[addr] <= 1'b1;
            end
            r_hit <= i_req.re && r_valid[addr];
        end
    end

    assign o_rdata = r_hit ? r_q : 8'd0;

    `ASSERT_NEXT(a_no_read_zero, i_clk, i_rst_n, i_req.en && !i_req.re, o_rdata == 8'd0)

endmodule

[rtl/rsfr_ctrl.sv]
// ----------------------------------------------------------------------------
// rsfr_ctrl
// Framing state, configuration registers and store access per item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsfr_ctrl #(
    parameter int BUFFER_BYTES = rsfr_pkg::BUFFER_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rsfr_pkg::t_cfg_wr  i_cfg,
    input  logic               i_acc,
    input  logic [1:0]         i_op,
    input  logic [7:0]         i_byte_in,
    input  logic [6:0]         i_read_index,
    output rsfr_pkg::t_res     o_res,
    output rsfr_pkg::t_mem_req o_mem
);
    import rsfr_pkg::*;

    localparam int DEPTH = BUFFER_BYTES + 2;
    localparam logic [7:0] DEPTH_B = 8'(DEPTH);
    localparam logic [7:0] MAXLEN  = 8'(BUFFER_BYTES);

    logic       r_node_mode, r_skip_pre, r_no_header;
    logic [7:0] r_len_pos, r_len_scale, r_len_off;

    logic [7:0] r_wp, r_len, r_sum;
    logic       r_done, r_start;
    logic [7:0] n_wp, n_len, n_sum;
    logic       n_done, n_start;

    // only the low byte of the scaled length matters
    logic [7:0]  prod;
    logic [7:0]  ri_ext;

    assign prod   = r_len_scale * i_byte_in;
    assign ri_ext = {1'b0, i_read_index};

    always_comb begin
        t_status st;
        logic    bad_len;
        logic    is_len_pos;
        st         = ST_BUSY;
        n_wp       = r_wp;
        n_len      = r_len;
        n_sum      = r_sum;
        n_done     = r_done;
        n_start    = r_start;
        o_mem      = '0;
        o_mem.en   = i_acc;
        o_mem.wdata = i_byte_in;
        bad_len    = (i_byte_in == 8'd0) || (i_byte_in > MAXLEN);
        is_len_pos = r_node_mode ? (r_wp == r_len_pos) : (r_wp == 8'd1);

        case (i_op)
            OP_BYTE: begin
                if (r_done) begin
                    st = ST_BUSY;
                end else if (r_wp == 8'd0 && i_byte_in == PREAMBLE_BYTE &&
                             (!r_node_mode || r_skip_pre)) begin
                    st = ST_PREAMBLE;
                end else if (is_len_pos && bad_len) begin
                    st      = ST_BADLEN;
                    n_wp    = 8'd0;
                    n_len   = 8'd0;
                    n_sum   = 8'd0;
                    n_done  = 1'b0;
                    n_start = 1'b0;
                end else begin
                    if (r_wp == 8'd0 &&
                        (i_byte_in == HEADER_BYTE || (r_node_mode && r_no_header))) begin
                        n_start = 1'b1;
                        n_len   = 8'd0;
                    end
                    if (is_len_pos) begin
                        n_len = r_node_mode ? 8'(prod + r_len_off) : i_byte_in;
                    end
                    o_mem.we   = (r_wp < DEPTH_B);
                    o_mem.addr = r_wp;
                    if (r_node_mode) begin
                        if (n_len != 8'd0 && ({1'b0, r_wp} + 9'd1) >= {1'b0, n_len}) begin
                            n_done = 1'b1;
                            st     = ST_DONE;
                        end else begin
                            n_wp = 8'(r_wp + 8'd1);
                            st   = ST_STORED;
                        end
                    end else if (n_len != 8'd0 && r_wp > n_len) begin
                        if (r_sum != i_byte_in && i_byte_in != PREAMBLE_BYTE) begin
                            st      = ST_BADSUM;
                            n_wp    = 8'd0;
                            n_len   = 8'd0;
                            n_sum   = 8'd0;
                            n_done  = 1'b0;
                            n_start = 1'b0;
                        end else begin
                            n_done = 1'b1;
                            st     = ST_DONE;
                        end
                    end else begin
                        if (r_wp != 8'd0) begin
                            n_sum = 8'(r_sum + i_byte_in);
                        end
                        n_wp = 8'(r_wp + 8'd1);
                        st   = ST_STORED;
                    end
                end
            end
            OP_RELEASE: begin
                st      = ST_RELEASED;
                n_wp    = 8'd0;
                n_len   = 8'd0;
                n_sum   = 8'd0;
                n_done  = 1'b0;
                n_start = 1'b0;
            end
            OP_READ: begin
                st         = ST_READ;
                o_mem.re   = (ri_ext < DEPTH_B);
                o_mem.addr = ri_ext;
            end
            default: begin
                st = ST_BUSY;
            end
        endcase

        o_res.status       = st;
        o_res.frame_ready  = n_done;
        o_res.frame_length = n_len;
        o_res.start_seen   = n_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 8'd0;
            r_len   <= 8'd0;
            r_sum   <= 8'd0;
            r_done  <= 1'b0;
            r_start <= 1'b0;
        end else if (i_acc) begin
            r_wp    <= n_wp;
            r_len   <= n_len;
            r_sum   <= n_sum;
            r_done  <= n_done;
            r_start <= n_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_mode <= 1'b0;
            r_skip_pre  <= 1'b1;
            r_no_header <= 1'b0;
            r_len_pos   <= 8'd1;
            r_len_scale <= 8'd1;
            r_len_off   <= 8'd0;
        end else if (i_cfg.we) begin
            case (i_cfg.index)
                CFG_NODE_MODE:  r_node_mode <= i_cfg.data[0];
                CFG_SKIP_PRE:   r_skip_pre  <= i_cfg.data[0];
                CFG_NO_HEADER:  r_no_header <= i_cfg.data[0];
                CFG_LEN_POS:    r_len_pos   <= i_cfg.data;
                CFG_LEN_SCALE:  r_len_scale <= i_cfg.data;
                CFG_LEN_OFFSET: r_len_off   <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    `ASSERT_NEXT(a_abort_restarts, i_clk, i_rst_n, i_acc && (o_res.status == ST_BADLEN || o_res.status == ST_BADSUM), r_wp == 8'd0 && !r_start && !r_done)

endmodule

[rtl/rs485_frame_receiver.sv]
// Pipeline: an accepted beat waits in stage 1 for the store read data, then
//   moves to the output register. Two register stages (store read, output).
// Throughput: one item per cycle unless the output stalls; the store takes at
//   most one write or read per item; length scaling is a single 8x8 multiply.
// Reset: synchronous, active low; framing state and configuration go to their
//   defaults and the store's valid bits clear, so unwritten entries read zero.
// ----------------------------------------------------------------------------
// rs485_frame_receiver
// Length-prefixed serial frame receiver with sum checksum (host mode) or
// scaled length field (node mode), frame buffer with read-back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rs485_frame_receiver #(
    parameter int BUFFER_BYTES = rsfr_pkg::BUFFER_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write port
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_op,
    input  logic [7:0] i_byte_in,
    input  logic [6:0] i_read_index,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_status,
    output logic       o_frame_ready,
    output logic [7:0] o_frame_length,
    output logic       o_start_seen,
    output logic [7:0] o_read_data
);
    import rsfr_pkg::*;

    t_cfg_wr  cfg;
    t_res     res;
    t_mem_req mem_req;
    logic [7:0] rdata;
    logic       acc;
    logic       s1_adv;

    // stage 1: decoded beat, waiting for the store read data
    logic r_s1_vld;
    t_res r_s1_res;
    // output register
    logic       r_o_vld;
    t_res       r_o_res;
    logic [7:0] r_o_rdata;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    // advance stage 1 whenever the output register is free or being drained;
    // accept a new beat whenever stage 1 is empty or advancing
    assign s1_adv     = !r_o_vld || !i_out_stall;
    assign o_in_stall = r_s1_vld && !s1_adv;
    assign acc        = i_in_valid && !o_in_stall;

    rsfr_ctrl #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_acc        (acc),
        .i_op         (i_op),
        .i_byte_in    (i_byte_in),
        .i_read_index (i_read_index),
        .o_res        (res),
        .o_mem        (mem_req)
    );

    // store read data stays put until the next accepted beat, which only
    // happens once stage 1 has moved on
    rsfr_store #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_o_vld <= r_s1_vld;
            end
        end
    end

    // hold payloads while stalled
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_res <= res;
        end
        if (s1_adv && r_s1_vld) begin
            r_o_res   <= r_s1_res;
            r_o_rdata <= rdata;
        end
    end

    assign o_out_valid    = r_o_vld;
    assign o_status       = r_o_res.status;
    assign o_frame_ready  = r_o_res.frame_ready;
    assign o_frame_length = r_o_res.frame_length;
    assign o_start_seen   = r_o_res.start_seen;
    assign o_read_data    = r_o_rdata;

    `ASSERT_IMPLIES(a_ready_status, i_clk, i_rst_n, r_o_vld && (r_o_res.status == ST_STORED || r_o_res.status == ST_BADLEN || r_o_res.status == ST_BADSUM || r_o_res.status == ST_RELEASED), !r_o_res.frame_ready)
    `ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_vld && !s1_adv, r_s1_vld)

endmodule

[test/rs485_frame_receiver_test.sv]
// ----------------------------------------------------------------------------
// rs485_frame_receiver_test
// Self-checking bench for the frame receiver. A local model of the framing
// state and the frame store predicts every result beat; the beats are checked
// in order, field by field. Directed host traffic comes first, then random
// host frames, node framing under several settings (the extremes among them),
// mode changes in the middle of a frame, and noise on all operations. Both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
module rs485_frame_receiver_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rsfr_pkg::*;

    localparam int STORE_DEPTH   = BUFFER_BYTES_DEF + 2;
    localparam int SETTLE_CYCLES = 8;     // extra wait after the two pipeline stages drain
    localparam int QUIET_LIMIT   = 2000;  // cycles without any beat before giving up
    localparam int REPORT_LIMIT  = 40;    // mismatches printed; the rest are only counted
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // one expected result beat
    typedef struct packed {
        t_status    status;
        logic       frame_ready;
        logic [7:0] frame_length;
        logic       start_seen;
        logic [7:0] read_data;
    } rx_result_t;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_cfg_we     = 1'b0;
    logic [2:0] i_cfg_index  = CFG_NODE_MODE;
    logic [7:0] i_cfg_data   = 8'h00;
    logic       i_in_valid   = 1'b0;
    logic [1:0] i_op         = OP_BYTE;
    logic [7:0] i_byte_in    = 8'h00;
    logic [6:0] i_read_index = 7'd0;
    logic       i_out_stall  = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [2:0] o_status;
    logic       o_frame_ready;
    logic [7:0] o_frame_length;
    logic       o_start_seen;
    logic [7:0] o_read_data;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    rs485_frame_receiver DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_byte_in      (i_byte_in),
        .i_read_index   (i_read_index),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_frame_ready  (o_frame_ready),
        .o_frame_length (o_frame_length),
        .o_start_seen   (o_start_seen),
        .o_read_data    (o_read_data)
    );

    // ------------------------------------------------------------------------
    // Receiver model: framing state, frame store and register copies
    // ------------------------------------------------------------------------
    logic [7:0] rx_store [STORE_DEPTH];
    logic [7:0] rx_pos;
    logic [7:0] rx_len;
    logic [7:0] rx_sum;
    logic       rx_done;
    logic       rx_start;

    logic       cfg_node;
    logic       cfg_skip;
    logic       cfg_nohdr;
    logic [7:0] cfg_lpos;
    logic [7:0] cfg_lscale;
    logic [7:0] cfg_loff;

    rx_result_t results_due[$];   // predicted beats, oldest first
    t_status    last_status;      // outcome of the most recent byte sent
    int         idle_pct  = 0;    // sender idle chance per cycle, percent
    int         stall_pct = 0;    // receiver stall chance per cycle, percent
    int         fail_count = 0;
    int         quiet_cycles = 0;

    function automatic void rx_restart();
        rx_pos   = 8'd0;
        rx_len   = 8'd0;
        rx_sum   = 8'd0;
        rx_done  = 1'b0;
        rx_start = 1'b0;
    endfunction

    function automatic void model_reset();
        foreach (rx_store[k]) rx_store[k] = 8'h00;
        rx_restart();
        cfg_node   = 1'b0;
        cfg_skip   = 1'b1;
        cfg_nohdr  = 1'b0;
        cfg_lpos   = 8'd1;
        cfg_lscale = 8'd1;
        cfg_loff   = 8'd0;
    endfunction

    // Host framing: length at position 1, sum check byte right after the payload.
    function automatic t_status host_byte(logic [7:0] b);
        if (rx_pos == 8'd0 && b == PREAMBLE_BYTE) return ST_PREAMBLE;
        if (rx_pos == 8'd0 && b == HEADER_BYTE) begin
            rx_start = 1'b1;
            rx_len   = 8'd0;
        end
        if (rx_pos == 8'd1) begin
            if (b == 8'd0 || b > BUFFER_BYTES_DEF) begin
                rx_restart();
                return ST_BADLEN;
            end
            rx_len = b;
        end
        if (rx_pos < STORE_DEPTH) rx_store[rx_pos] = b;
        if (rx_len != 8'd0 && rx_pos > rx_len) begin
            // a preamble byte in the check slot is always accepted
            if (rx_sum != b && b != PREAMBLE_BYTE) begin
                rx_restart();
                return ST_BADSUM;
            end
            rx_done = 1'b1;
            return ST_DONE;
        end
        if (rx_pos >= 8'd1) rx_sum = rx_sum + b;
        rx_pos = rx_pos + 8'd1;
        return ST_STORED;
    endfunction

    // Node framing: length at a set position, scaled mod 256, no check byte.
    function automatic t_status node_byte(logic [7:0] b);
        logic [15:0] scaled;
        if (rx_pos == 8'd0 && b == PREAMBLE_BYTE && cfg_skip) return ST_PREAMBLE;
        if (rx_pos == 8'd0 && (b == HEADER_BYTE || cfg_nohdr)) begin
            rx_start = 1'b1;
            rx_len   = 8'd0;
        end
        if (rx_pos == cfg_lpos) begin
            // bounds apply to the raw byte, before scaling
            if (b == 8'd0 || b > BUFFER_BYTES_DEF) begin
                rx_restart();
                return ST_BADLEN;
            end
            scaled = cfg_lscale * b + cfg_loff;
            rx_len = scaled[7:0];
        end
        if (rx_pos < STORE_DEPTH) rx_store[rx_pos] = b;
        if (rx_len != 8'd0 && {1'b0, rx_pos} + 9'd1 >= {1'b0, rx_len}) begin
            rx_done = 1'b1;
            return ST_DONE;
        end
        rx_pos = rx_pos + 8'd1;
        return ST_STORED;
    endfunction

    // Advance the model by one input beat and return the beat it must produce.
    function automatic rx_result_t frame_step(logic [1:0] op, logic [7:0] b, logic [6:0] ri);
        rx_result_t r;
        r.status    = ST_BUSY;
        r.read_data = 8'h00;
        case (op)
            OP_BYTE: begin
                if (!rx_done) r.status = cfg_node ? node_byte(b) : host_byte(b);
            end
            OP_RELEASE: begin
                rx_restart();
                r.status = ST_RELEASED;
            end
            OP_READ: begin
                if (ri < STORE_DEPTH) r.read_data = rx_store[ri];
                r.status = ST_READ;
            end
            default: ;  // unused code: no state change
        endcase
        r.frame_ready  = rx_done;
        r.frame_length = rx_len;
        r.start_seen   = rx_start;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------------
    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [6:0] rand_index();
        return 7'($urandom_range(0, 127));
    endfunction

    // mostly inside the store, sometimes past it
    function automatic logic [6:0] draw_index();
        if ($urandom_range(0, 9) != 0) return 7'($urandom_range(0, STORE_DEPTH - 1));
        return 7'($urandom_range(STORE_DEPTH, 127));
    endfunction

    // mostly short lengths, the full buffer now and then, and some bad ones
    function automatic logic [7:0] draw_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 75) return 8'($urandom_range(1, 8));
        if (pick < 85) return 8'($urandom_range(9, BUFFER_BYTES_DEF));
        if (pick < 90) return 8'(BUFFER_BYTES_DEF);
        if (pick < 95) return 8'd0;
        return 8'($urandom_range(BUFFER_BYTES_DEF + 1, 255));
    endfunction

    // ------------------------------------------------------------------------
    // Input side: send one beat, predict it once accepted
    // ------------------------------------------------------------------------
    task automatic send_beat(input logic [1:0] op, input logic [7:0] b, input logic [6:0] ri);
        rx_result_t want;
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_byte_in    <= b;
        i_read_index <= ri;
        @(posedge i_clk);
        // hold the payload until the edge that takes it
        while (o_in_stall) @(posedge i_clk);
        want = frame_step(op, b, ri);
        last_status = want.status;
        results_due.push_back(want);
    endtask

    // Drop valid, let every predicted beat arrive, then give the pipe time to empty.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_NODE_MODE:  cfg_node   = val[0];
            CFG_SKIP_PRE:   cfg_skip   = val[0];
            CFG_NO_HEADER:  cfg_nohdr  = val[0];
            CFG_LEN_POS:    cfg_lpos   = val;
            CFG_LEN_SCALE:  cfg_lscale = val;
            CFG_LEN_OFFSET: cfg_loff   = val;
            default: ;
        endcase
    endtask

    // Wait for idle, then load all six registers.
    task automatic apply_setup(input logic node, input logic skip, input logic nohdr,
                               input logic [7:0] lpos, input logic [7:0] scale,
                               input logic [7:0] offs);
        settle();
        write_reg(CFG_NODE_MODE,  {7'd0, node});
        write_reg(CFG_SKIP_PRE,   {7'd0, skip});
        write_reg(CFG_NO_HEADER,  {7'd0, nohdr});
        write_reg(CFG_LEN_POS,    lpos);
        write_reg(CFG_LEN_SCALE,  scale);
        write_reg(CFG_LEN_OFFSET, offs);
    endtask

    task automatic send_noise();
        send_beat(2'($urandom_range(0, 3)), rand_byte(), rand_index());
    endtask

    // After a frame: stray bytes, read-back, usually a release.
    task automatic send_frame_tail();
        repeat ($urandom_range(0, 2)) send_beat(OP_BYTE, rand_byte(), rand_index());
        repeat ($urandom_range(0, 2)) send_beat(OP_READ, rand_byte(), draw_index());
        if ($urandom_range(0, 9) != 0) send_beat(OP_RELEASE, rand_byte(), rand_index());
        if ($urandom_range(0, 4) == 0) send_noise();
    endtask

    // Host frame: preamble, header, length, payload, check byte (mostly right).
    task automatic send_host_frame();
        logic [7:0] len;
        logic [7:0] sum;
        logic [7:0] b;
        int         pick;
        repeat ($urandom_range(0, 2)) send_beat(OP_BYTE, PREAMBLE_BYTE, rand_index());
        b = ($urandom_range(0, 9) != 0) ? HEADER_BYTE : rand_byte();
        send_beat(OP_BYTE, b, rand_index());
        len = draw_length();
        send_beat(OP_BYTE, len, rand_index());
        sum = len;
        if (len != 8'd0 && len <= BUFFER_BYTES_DEF) begin
            for (int i = 2; i <= len; i++) begin
                b = rand_byte();
                send_beat(OP_BYTE, b, rand_index());
                sum = sum + b;
            end
            pick = $urandom_range(0, 99);
            if (pick < 75)      b = sum;
            else if (pick < 85) b = PREAMBLE_BYTE;
            else                b = sum ^ 8'($urandom_range(1, 255));
            send_beat(OP_BYTE, b, rand_index());
        end
        send_frame_tail();
    endtask

    // Node frame: feed bytes, placing a length at the set position, until the
    // frame completes, the length is rejected or the byte budget runs out.
    task automatic send_node_frame(input int max_bytes);
        logic [7:0] b;
        int         sent;
        if (cfg_skip && $urandom_range(0, 3) == 0)
            send_beat(OP_BYTE, PREAMBLE_BYTE, rand_index());
        sent = 0;
        while (!rx_done && sent < max_bytes) begin
            if (rx_pos == cfg_lpos)
                b = draw_length();
            else if (rx_pos == 8'd0 && $urandom_range(0, 9) != 0)
                b = HEADER_BYTE;
            else
                b = rand_byte();
            send_beat(OP_BYTE, b, rand_index());
            sent++;
            if (last_status == ST_BADLEN) break;
        end
        send_frame_tail();
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Host framing corner cases, one beat at a time.
    task automatic test_host_directed();
        send_beat(OP_READ, 8'h00, 7'd0);              // store reads zero after reset
        send_beat(OP_BYTE, PREAMBLE_BYTE, 7'd0);      // preamble skipped
        send_beat(OP_BYTE, HEADER_BYTE, 7'd0);
        send_beat(OP_BYTE, 8'd0, 7'd0);               // zero length: abort
        send_beat(OP_BYTE, HEADER_BYTE, 7'd0);
        send_beat(OP_BYTE, 8'd65, 7'd0);              // one past the buffer: abort
        send_beat(OP_BYTE, HEADER_BYTE, 7'd0);
        send_beat(OP_BYTE, 8'd2, 7'd0);
        send_beat(OP_BYTE, 8'h11, 7'd0);
        send_beat(OP_BYTE, 8'h13, 7'd0);              // right sum: frame done
        send_beat(OP_BYTE, 8'hFF, 7'h7F);             // held frame: ignored
        send_beat(OP_READ, 8'hFF, 7'd1);
        send_beat(OP_READ, 8'h00, 7'd65);             // last store entry
        send_beat(OP_READ, 8'h00, 7'd66);             // past the store
        send_beat(OP_READ, 8'h00, 7'd127);
        send_beat(OP_UNUSED, 8'hFF, 7'h7F);           // unused code: ignored
        send_beat(OP_RELEASE, 8'h00, 7'd0);
        send_beat(OP_BYTE, 8'h00, 7'd0);              // no header byte
        send_beat(OP_BYTE, 8'd1, 7'd0);
        send_beat(OP_BYTE, PREAMBLE_BYTE, 7'd0);      // preamble in the check slot passes
        send_beat(OP_RELEASE, 8'h00, 7'd0);
        send_beat(OP_BYTE, 8'hFF, 7'd0);
        send_beat(OP_BYTE, 8'd1, 7'd0);
        send_beat(OP_BYTE, 8'h00, 7'd0);              // wrong sum: abort
    endtask

    // Random host frames; the first stretch runs without any idling.
    task automatic test_host_frames();
        idle_pct  = 0;
        stall_pct = 0;
        repeat (8) send_host_frame();
        idle_pct  = 17;
        stall_pct = 17;
        repeat (20) begin
            send_host_frame();
            if ($urandom_range(0, 4) == 0) send_noise();
        end
    endtask

    // Node framing under fixed and random settings, the extremes among them.
    task automatic test_node_settings();
        apply_setup(1'b1, 1'b1, 1'b0, 8'd1, 8'd1, 8'd0);
        repeat (6) send_node_frame(80);
        apply_setup(1'b1, 1'b0, 1'b1, 8'd0, 8'd2, 8'd3);
        repeat (6) send_node_frame(80);
        // largest scale and offset: lengths near 256, writes run past the store
        apply_setup(1'b1, 1'b1, 1'b1, 8'd3, 8'd255, 8'd255);
        send_node_frame(300);
        // zero scale: the frame never completes and the position wraps
        apply_setup(1'b1, 1'b0, 1'b0, 8'd5, 8'd0, 8'd0);
        send_node_frame(300);
        // length field at the last position
        apply_setup(1'b1, 1'b1, 1'b0, 8'd255, 8'd1, 8'd0);
        send_node_frame(300);
        repeat (4) begin
            apply_setup(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        8'($urandom_range(0, 6)), 8'($urandom_range(1, 4)),
                        8'($urandom_range(0, 10)));
            repeat (3) send_node_frame(80);
        end
    endtask

    // Switch framing mode in the middle of a frame; the state carries over.
    task automatic test_mode_switch();
        apply_setup(1'b0, 1'b1, 1'b0, 8'd1, 8'd1, 8'd0);
        send_beat(OP_BYTE, HEADER_BYTE, rand_index());
        send_beat(OP_BYTE, 8'd5, rand_index());
        send_beat(OP_BYTE, 8'h01, rand_index());
        send_beat(OP_BYTE, 8'h02, rand_index());
        settle();
        write_reg(CFG_NODE_MODE, 8'd1);
        send_node_frame(40);
        send_beat(OP_RELEASE, rand_byte(), rand_index());
        send_beat(OP_BYTE, HEADER_BYTE, rand_index());
        send_beat(OP_BYTE, 8'd3, rand_index());
        settle();
        write_reg(CFG_NODE_MODE, 8'd0);
        repeat (4) send_beat(OP_BYTE, rand_byte(), rand_index());
        repeat (20) send_noise();
        send_beat(OP_RELEASE, rand_byte(), rand_index());
        repeat (4) send_host_frame();
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stall, in-order check of every result beat
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        rx_result_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (results_due.size() == 0) begin
                fail_count++;
                $error("result beat with nothing expected");
            end else begin
                want = results_due.pop_front();
                check_field("status",       8'(want.status),      8'(o_status));
                check_field("frame_ready",  8'(want.frame_ready), 8'(o_frame_ready));
                check_field("frame_length", want.frame_length,    o_frame_length);
                check_field("start_seen",   8'(want.start_seen),  8'(o_start_seen));
                check_field("read_data",    want.read_data,       o_read_data);
            end
        end
    end

    // Watchdog: end the run when no beat moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        model_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_host_directed();
        test_host_frames();
        test_node_settings();
        test_mode_switch();
        settle();

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
